// ----- rtl/rle_frame_decoder_unit_assert.svh -----
// Assertion shorthands for the decoder modules; only rlefd_decode includes them.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef RLE_FRAME_DECODER_UNIT_ASSERT_SVH
`define RLE_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RLEFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLEFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rlefd_pkg.sv -----
package rlefd_pkg;

  // Decoder position within a frame.
  typedef enum logic [2:0] {
    PH_X     = 3'd0,
    PH_Y     = 3'd1,
    PH_WIDTH = 3'd2,
    PH_HGT   = 3'd3,
    PH_HOLD  = 3'd4,
    PH_RUNS  = 3'd5,
    PH_COUNT = 3'd6,
    PH_COLOR = 3'd7
  } phase_e;

  // Frame end status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_WINDOW     = 3'd1,
    ST_NO_RUNS    = 3'd2,
    ST_ZERO_COUNT = 3'd3,
    ST_OVERRUN    = 3'd4,
    ST_UNDERRUN   = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_index_e;

  localparam int unsigned CfgWidth = 11;

  // One decoded result item plus a flag that says whether the word made one.
  typedef struct packed {
    logic        has_result;
    logic        fill_valid;
    logic [19:0] fill_offset;
    logic [15:0] fill_count;
    logic [15:0] fill_color;
    logic        frame_end;
    status_e     frame_status;
    logic [15:0] win_x;
    logic [15:0] win_y;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic [15:0] hold_ms;
  } result_t;

endpackage

// ----- rtl/rle_frame_decoder_unit.sv -----
// Run-length frame decoder. One stream word is accepted per cycle while the
// result register has space, with no gaps between frames; header and count
// words make no result, a color word or a rejected run-count word makes one.
// A word is held in the input register, and its result is captured in the
// result register until the sink takes it. The rate is set by the single
// decode step between the input and result registers, which takes one word
// per cycle whenever the result register is empty or drained in that cycle.
// The user writes screen size through the configuration port only while no
// item is open; the block itself does not enforce this.
module rle_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] stream_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fill_valid_o,
  output logic [19:0] fill_offset_o,
  output logic [15:0] fill_count_o,
  output logic [15:0] fill_color_o,
  output logic        frame_end_o,
  output logic [2:0]  frame_status_o,
  output logic [15:0] win_x_o,
  output logic [15:0] win_y_o,
  output logic [15:0] win_width_o,
  output logic [15:0] win_height_o,
  output logic [15:0] hold_ms_o
);

  import rlefd_pkg::*;

  logic        word_valid;
  logic [15:0] word;
  logic        space;
  logic        adv;
  result_t     dec_res;
  result_t     out_res;

  // A word is consumed when one is held and its result has somewhere to go.
  assign adv = word_valid && space;

  rlefd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_word_i (stream_word_i),
    .adv_i         (adv),
    .word_valid_o  (word_valid),
    .word_o        (word)
  );

  rlefd_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (adv),
    .word_i      (word),
    .res_o       (dec_res)
  );

  rlefd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_i       (dec_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Result fields onto the output ports.
  assign fill_valid_o   = out_res.fill_valid;
  assign fill_offset_o  = out_res.fill_offset;
  assign fill_count_o   = out_res.fill_count;
  assign fill_color_o   = out_res.fill_color;
  assign frame_end_o    = out_res.frame_end;
  assign frame_status_o = out_res.frame_status;
  assign win_x_o        = out_res.win_x;
  assign win_y_o        = out_res.win_y;
  assign win_width_o    = out_res.win_width;
  assign win_height_o   = out_res.win_height;
  assign hold_ms_o      = out_res.hold_ms;

endmodule

// ----- rtl/rlefd_in_stage.sv -----
// Input register: holds one stream word until the decode step consumes it.
module rlefd_in_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] stream_word_i,
  input  logic        adv_i,
  output logic        word_valid_o,
  output logic [15:0] word_o
);

  logic        valid_q;
  logic [15:0] word_q;

  // The register frees up in the same cycle its word is consumed.
  assign in_ready_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= stream_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ----- rtl/rlefd_decode.sv -----
// Frame parser: header capture, window check, run bookkeeping and result build.
module rlefd_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [10:0]                 cfg_data_i,
  input  logic                        adv_i,
  input  logic [15:0]                 word_i,
  output rlefd_pkg::result_t          res_o
);

  import rlefd_pkg::*;

  `include "rle_frame_decoder_unit_assert.svh"

  phase_e phase_q, phase_d;
  logic [CfgWidth-1:0] screen_width_q, screen_height_q;
  logic [15:0] hdr_x_q, hdr_y_q, hdr_width_q, hdr_height_q, hdr_hold_q;
  logic [15:0] hdr_x_d, hdr_y_d, hdr_width_d, hdr_height_d, hdr_hold_d;
  logic [15:0] runs_left_q, runs_left_d;
  logic [20:0] pixel_cursor_q, pixel_cursor_d;
  logic [20:0] area_total_q, area_total_d;
  logic [15:0] pending_count_q, pending_count_d;

  logic [16:0] x_extent, y_extent;
  logic        win_bad;
  logic [31:0] area_full;
  logic [21:0] run_end;
  logic        overrun;
  logic [15:0] runs_dec;

  // Window check and area; the header registers are stable by the run-count word.
  assign x_extent  = {1'b0, hdr_x_q} + {1'b0, hdr_width_q};
  assign y_extent  = {1'b0, hdr_y_q} + {1'b0, hdr_height_q};
  assign win_bad   = (x_extent > {6'd0, screen_width_q}) ||
                     (y_extent > {6'd0, screen_height_q});
  assign area_full = hdr_width_q * hdr_height_q;

  // Run bounds for the color word.
  assign run_end  = {1'b0, pixel_cursor_q} + {6'd0, pending_count_q};
  assign overrun  = run_end > {1'b0, area_total_q};
  assign runs_dec = runs_left_q - 16'd1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= CfgWidth'(320);
      screen_height_q <= CfgWidth'(172);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_d         = phase_q;
    hdr_x_d         = hdr_x_q;
    hdr_y_d         = hdr_y_q;
    hdr_width_d     = hdr_width_q;
    hdr_height_d    = hdr_height_q;
    hdr_hold_d      = hdr_hold_q;
    runs_left_d     = runs_left_q;
    pixel_cursor_d  = pixel_cursor_q;
    area_total_d    = area_total_q;
    pending_count_d = pending_count_q;
    case (phase_q)
      PH_X: begin
        hdr_x_d = word_i;
        phase_d = PH_Y;
      end
      PH_Y: begin
        hdr_y_d = word_i;
        phase_d = PH_WIDTH;
      end
      PH_WIDTH: begin
        hdr_width_d = word_i;
        phase_d     = PH_HGT;
      end
      PH_HGT: begin
        hdr_height_d = word_i;
        phase_d      = PH_HOLD;
      end
      PH_HOLD: begin
        hdr_hold_d = word_i;
        phase_d    = PH_RUNS;
      end
      PH_RUNS: begin
        if (win_bad || word_i == 16'd0) begin
          phase_d = PH_X;
        end else begin
          runs_left_d    = word_i;
          pixel_cursor_d = '0;
          area_total_d   = area_full[20:0];
          phase_d        = PH_COUNT;
        end
      end
      PH_COUNT: begin
        pending_count_d = word_i;
        phase_d         = PH_COLOR;
      end
      PH_COLOR: begin
        if (pending_count_q == 16'd0 || overrun) begin
          phase_d = PH_X;
        end else begin
          pixel_cursor_d = run_end[20:0];
          runs_left_d    = runs_dec;
          phase_d        = (runs_dec == 16'd0) ? PH_X : PH_COUNT;
        end
      end
      default: phase_d = PH_X;
    endcase
  end

  // Result for the current word.
  always_comb begin
    res_o              = '0;
    res_o.frame_status = ST_OK;
    res_o.win_x        = hdr_x_q;
    res_o.win_y        = hdr_y_q;
    res_o.win_width    = hdr_width_q;
    res_o.win_height   = hdr_height_q;
    res_o.hold_ms      = (hdr_hold_q == 16'd0) ? 16'd1 : hdr_hold_q;
    case (phase_q)
      PH_RUNS: begin
        if (win_bad) begin
          res_o.has_result   = 1'b1;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_WINDOW;
        end else if (word_i == 16'd0) begin
          res_o.has_result   = 1'b1;
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_NO_RUNS;
        end
      end
      PH_COLOR: begin
        res_o.has_result = 1'b1;
        if (pending_count_q == 16'd0) begin
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_ZERO_COUNT;
        end else if (overrun) begin
          res_o.frame_end    = 1'b1;
          res_o.frame_status = ST_OVERRUN;
        end else begin
          res_o.fill_valid  = 1'b1;
          res_o.fill_offset = pixel_cursor_q[19:0];
          res_o.fill_count  = pending_count_q;
          res_o.fill_color  = word_i;
          if (runs_dec == 16'd0) begin
            res_o.frame_end    = 1'b1;
            res_o.frame_status = (run_end[20:0] == area_total_q) ? ST_OK : ST_UNDERRUN;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_X;
      hdr_x_q         <= '0;
      hdr_y_q         <= '0;
      hdr_width_q     <= '0;
      hdr_height_q    <= '0;
      hdr_hold_q      <= '0;
      runs_left_q     <= '0;
      pixel_cursor_q  <= '0;
      area_total_q    <= '0;
      pending_count_q <= '0;
    end else if (adv_i) begin
      phase_q         <= phase_d;
      hdr_x_q         <= hdr_x_d;
      hdr_y_q         <= hdr_y_d;
      hdr_width_q     <= hdr_width_d;
      hdr_height_q    <= hdr_height_d;
      hdr_hold_q      <= hdr_hold_d;
      runs_left_q     <= runs_left_d;
      pixel_cursor_q  <= pixel_cursor_d;
      area_total_q    <= area_total_d;
      pending_count_q <= pending_count_d;
    end
  end

  // The cursor never passes the window area while runs are open.
  `RLEFD_ASSERT_IMP(a_cursor_in_area, (phase_q == PH_COUNT || phase_q == PH_COLOR), (pixel_cursor_q <= area_total_q), "pixel cursor beyond window area")
  // A frame with open runs always has at least one run left.
  `RLEFD_ASSERT_IMP(a_runs_open, (phase_q == PH_COUNT || phase_q == PH_COLOR), (runs_left_q != 16'd0), "run pair expected with no runs left")
  // A fill never carries an empty run.
  `RLEFD_ASSERT_IMP(a_fill_nonzero, res_o.fill_valid, (res_o.fill_count != 16'd0 && res_o.has_result), "fill with zero count")
  // Ending a frame always returns to header parsing.
  `RLEFD_ASSERT_NXT(a_end_to_header, (adv_i && res_o.frame_end), (phase_q == PH_X), "frame end did not restart header")

endmodule

// ----- rtl/rlefd_out_stage.sv -----
// Result register: holds one result item until the sink takes it.
module rlefd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  rlefd_pkg::result_t res_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rlefd_pkg::result_t res_o
);

  import rlefd_pkg::*;

  logic    valid_q;
  result_t res_q;

  // A new result may land when the register is empty or is drained this cycle.
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i && res_i.has_result) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_i.has_result) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
